@@ rtl/core/mtd_pkg.sv @@
// Shared widths, constants and stage structs for the median threshold hit detector.
`timescale 1ns / 1ps

package mtd_pkg;

  localparam int POWER_W    = 32;                 // 16.16 unsigned power value
  localparam int FACTOR_W   = 10;                 // threshold factor register
  localparam int PROD_W     = POWER_W + FACTOR_W; // exact median * factor
  localparam int CNT_W      = 16;                 // per-channel hit counter
  localparam int CH_IDX_W   = 4;                  // channel index field
  localparam int OUT_DATA_W = 24;                 // result tdata, padded to bytes

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd250;

  // Merge stage to hit stage
  typedef struct packed {
    logic [PROD_W-1:0]   thresh;
    logic [POWER_W-1:0]  peak;
    logic [CH_IDX_W-1:0] best;
    logic                lockout;
    logic                clear;
  } mtd_stage_t;

  // One result item
  typedef struct packed {
    logic                hit;
    logic [CH_IDX_W-1:0] hit_channel;
    logic [CNT_W-1:0]    channel_count;
    logic                hit_pending;
  } mtd_result_t;

endpackage

@@ rtl/core/mtd_rank_lane.sv @@
// One ranking lane: stable rank of its own channel and first-strongest test.
`timescale 1ns / 1ps

module mtd_rank_lane import mtd_pkg::*; #(
  parameter int CHANNELS = 10,
  parameter int LANE     = 0,
  parameter int RANK     = 4
) (
  input  logic [POWER_W-1:0] power_i [CHANNELS],
  output logic               is_med_o,
  output logic               is_best_o
);

  localparam int RW = $clog2(CHANNELS);

  logic [RW-1:0] rank;

  // Stable rank: earlier equal values count as smaller.
  // Best: strictly above every earlier channel, not below any later one.
  always_comb begin
    rank      = '0;
    is_best_o = 1'b1;
    for (int j = 0; j < CHANNELS; j++) begin
      if (j < LANE) begin
        if (power_i[j] <= power_i[LANE]) rank = rank + RW'(1);
        if (power_i[j] >= power_i[LANE]) is_best_o = 1'b0;
      end else if (j > LANE) begin
        if (power_i[j] < power_i[LANE]) rank = rank + RW'(1);
        if (power_i[j] > power_i[LANE]) is_best_o = 1'b0;
      end
    end
    is_med_o = (rank == RW'(RANK));
  end

endmodule

@@ rtl/core/mtd_merge.sv @@
// Merge stage: picks median and peak from the lane flags and forms the threshold.
`timescale 1ns / 1ps

module mtd_merge import mtd_pkg::*; #(
  parameter int CHANNELS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [POWER_W-1:0]  power_i [CHANNELS],
  input  logic [CHANNELS-1:0] is_med_i,
  input  logic [CHANNELS-1:0] is_best_i,
  input  logic [FACTOR_W-1:0] factor_i,
  input  logic                lockout_i,
  input  logic                clear_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtd_stage_t          stage_o
);

  logic [POWER_W-1:0] med;
  mtd_stage_t         stage_d;
  mtd_stage_t         stage_q;
  logic               v_q;

  // One-hot select of median and peak, index encode of the best lane
  always_comb begin
    med          = '0;
    stage_d      = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (is_med_i[i])  med = med | power_i[i];
      if (is_best_i[i]) begin
        stage_d.peak = stage_d.peak | power_i[i];
        stage_d.best = stage_d.best | CH_IDX_W'(i);
      end
    end
    stage_d.thresh  = PROD_W'(med) * PROD_W'(factor_i);
    stage_d.lockout = lockout_i;
    stage_d.clear   = clear_i;
  end

  assign in_ready_o = !v_q || out_ready_i;

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign out_valid_o = v_q;
  assign stage_o     = stage_q;

  a_med_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> $onehot(is_med_i))
    else $error("median lane select not one-hot");

  a_best_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> $onehot(is_best_i))
    else $error("best lane select not one-hot");

endmodule

@@ rtl/core/mtd_hit_update.sv @@
// Hit decision, per-channel counters, sticky pending flag and result register.
`timescale 1ns / 1ps

module mtd_hit_update import mtd_pkg::*; #(
  parameter int CHANNELS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mtd_stage_t  stage_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output mtd_result_t result_o
);

  localparam int IW = $clog2(CHANNELS);

  logic [CNT_W-1:0] cnt_q [CHANNELS];
  logic             pend_q;
  logic             pend_d;
  logic             out_valid_q;
  mtd_result_t      res_q;
  logic [IW-1:0]    sel;
  logic             hit_c;
  logic [CNT_W-1:0] cnt_new;
  logic             take;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign sel        = stage_i.best[IW-1:0];

  // Threshold compare, counter increment, clear before set
  always_comb begin
    hit_c   = !stage_i.lockout && (PROD_W'(stage_i.peak) > stage_i.thresh);
    cnt_new = cnt_q[sel] + CNT_W'(hit_c);
    pend_d  = hit_c || (pend_q && !stage_i.clear);
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) cnt_q[i] <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) out_valid_q <= in_valid_i;
      if (take) begin
        pend_q <= pend_d;
        if (hit_c) cnt_q[sel] <= cnt_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.hit           <= hit_c;
      res_q.hit_channel   <= stage_i.best;
      res_q.channel_count <= cnt_new;
      res_q.hit_pending   <= pend_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  a_lockout_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && stage_i.lockout |=> !res_q.hit)
    else $error("hit reported during lockout");

  a_hit_sets_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && hit_c |=> pend_q)
    else $error("pending flag not set by hit");

  a_hit_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.hit |-> res_q.hit_pending)
    else $error("hit result without pending flag");

endmodule

@@ rtl/core/median_threshold_hit_detector_unit.sv @@
// Registered path from an input transfer to its result on the master side:
// rank lanes, merge and multiply, hit decision into the output register.
// Throughput: one item per cycle; each stage holds while the next is full.
// The rate is set by the combinational rank lanes and the one 32x10 multiplier.
// Reset (rst_ni low, asynchronous): counters and pending flag cleared,
// threshold factor set to 250, pipeline emptied.
`timescale 1ns / 1ps

module median_threshold_hit_detector_unit import mtd_pkg::*; #(
  parameter int CHANNELS    = 10,
  parameter int MEDIAN_RANK = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: threshold factor
  input  logic                        cfg_we_i,
  input  logic [FACTOR_W-1:0]         cfg_wdata_i,
  // Slave side
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [CHANNELS*POWER_W-1:0] s_axis_tdata,  // power_0 .. power_(CHANNELS-1)
  input  logic [1:0]                  s_axis_tuser,  // lockout_active, clear_pending
  // Master side
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,  // hit_channel, channel_count, pad
  output logic [1:0]                  m_axis_tuser   // hit, hit_pending
);

  localparam int RANK_EFF = (MEDIAN_RANK >= CHANNELS) ? CHANNELS - 1 : MEDIAN_RANK;

  logic [FACTOR_W-1:0] factor_q;
  logic [POWER_W-1:0]  pow_in [CHANNELS];
  logic [POWER_W-1:0]  pow1_q [CHANNELS];
  logic [CHANNELS-1:0] med_vec;
  logic [CHANNELS-1:0] best_vec;
  logic [CHANNELS-1:0] med1_q;
  logic [CHANNELS-1:0] best1_q;
  logic                lock1_q;
  logic                clr1_q;
  logic                v1_q;
  logic                rdy1;
  logic                rdy2;
  logic                v2;
  logic                rdy3;
  mtd_stage_t          stage2;
  mtd_result_t         result;

  // Threshold factor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_we_i) begin
      factor_q <= cfg_wdata_i;
    end
  end

  // Rank lanes, one per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    assign pow_in[g] = s_axis_tdata[g*POWER_W +: POWER_W];

    mtd_rank_lane #(
      .CHANNELS (CHANNELS),
      .LANE     (g),
      .RANK     (RANK_EFF)
    ) u_lane (
      .power_i   (pow_in),
      .is_med_o  (med_vec[g]),
      .is_best_o (best_vec[g])
    );
  end

  // Lane stage registers
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      for (int i = 0; i < CHANNELS; i++) pow1_q[i] <= pow_in[i];
      med1_q  <= med_vec;
      best1_q <= best_vec;
      lock1_q <= s_axis_tuser[0];
      clr1_q  <= s_axis_tuser[1];
    end
  end

  // Merge lanes and form threshold
  mtd_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (rdy2),
    .power_i     (pow1_q),
    .is_med_i    (med1_q),
    .is_best_i   (best1_q),
    .factor_i    (factor_q),
    .lockout_i   (lock1_q),
    .clear_i     (clr1_q),
    .out_valid_o (v2),
    .out_ready_i (rdy3),
    .stage_o     (stage2)
  );

  // Hit decision and result register
  mtd_hit_update #(
    .CHANNELS (CHANNELS)
  ) u_hit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2),
    .in_ready_o  (rdy3),
    .stage_i     (stage2),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - CNT_W - CH_IDX_W){1'b0}},
                         result.channel_count, result.hit_channel};
  assign m_axis_tuser = {result.hit_pending, result.hit};

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the median threshold hit detector unit.
`timescale 1ns / 1ps

module tb_top import mtd_pkg::*; ();

  localparam int LANES      = 10;
  localparam int MEDIAN_AT  = 4;
  localparam int SET_W      = LANES * POWER_W;
  localparam int PHASE_LEN  = 135;
  localparam int BURST_LANE = 5;
  localparam int BURST_LEN  = 24;

  // Directed stimulus row; want is only used when typed is set
  typedef struct {
    logic [SET_W-1:0] powers;
    logic             lockout;
    logic             clear;
    logic             typed;
    mtd_result_t      want;
  } probe_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [FACTOR_W-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SET_W-1:0]    s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  // Shadow state of the block
  logic [CNT_W-1:0]    shadow_counts [LANES];
  logic                shadow_pending;
  logic [FACTOR_W-1:0] shadow_factor;

  mtd_result_t expected_results [$];
  probe_row_t  probes [$];
  int          mismatch_count = 0;
  int          stall_left     = 0;
  logic        no_idle        = 1'b0;

  always #5 clk_i = ~clk_i;

  median_threshold_hit_detector_unit #(
    .CHANNELS   (LANES),
    .MEDIAN_RANK(MEDIAN_AT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Gap length: mostly none, some short, a few long
  function automatic int idle_len(input int quiet_pct);
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < quiet_pct) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic logic [SET_W-1:0] set_lane(input logic [SET_W-1:0] p, input int lane,
                                                input logic [POWER_W-1:0] v);
    p[lane*POWER_W +: POWER_W] = v;
    return p;
  endfunction

  // Rank the set, compare peak with median * factor, update counters and flag
  function automatic mtd_result_t score_power_set(input logic [SET_W-1:0] powers,
                                                  input logic lockout, input logic clear);
    logic [POWER_W-1:0] ranked [LANES];
    logic [POWER_W-1:0] x;
    logic [PROD_W-1:0]  thresh;
    mtd_result_t        r;
    int                 best;
    int                 j;
    best = 0;
    for (int i = 0; i < LANES; i++) begin
      ranked[i] = powers[i*POWER_W +: POWER_W];
      if (ranked[i] > powers[best*POWER_W +: POWER_W]) best = i;
    end
    // insertion sort, smallest first
    for (int i = 1; i < LANES; i++) begin
      x = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > x) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = x;
    end
    if (clear) shadow_pending = 1'b0;
    thresh = PROD_W'(ranked[MEDIAN_AT]) * PROD_W'(shadow_factor);
    r.hit = !lockout && (PROD_W'(ranked[LANES-1]) > thresh);
    if (r.hit) begin
      shadow_counts[best] = shadow_counts[best] + 1'b1;
      shadow_pending = 1'b1;
    end
    r.hit_channel   = CH_IDX_W'(best);
    r.channel_count = shadow_counts[best];
    r.hit_pending   = shadow_pending;
    return r;
  endfunction

  // Random power set, in half the cases shaped so the peak sits around the threshold
  function automatic logic [SET_W-1:0] random_power_set();
    logic [SET_W-1:0]   p;
    logic [POWER_W-1:0] base;
    longint             target;
    int                 style;
    int                 start;
    int                 peak_lane;
    p = '0;
    style = $urandom_range(0, 9);
    case (style)
      0, 1: begin
        for (int i = 0; i < LANES; i++) p[i*POWER_W +: POWER_W] = $urandom();
      end
      2, 3, 4, 5, 6: begin
        base = $urandom_range(0, 1 << $urandom_range(0, 22));
        for (int i = 0; i < LANES; i++) p[i*POWER_W +: POWER_W] = $urandom_range(0, base);
        // five lanes at base pin the median to base when the peak lane is above base
        start = $urandom_range(0, LANES - 1);
        for (int i = 0; i < 5; i++) p = set_lane(p, (start + i) % LANES, base);
        target = longint'(base) * longint'(shadow_factor) + longint'($urandom_range(0, 2)) - 1;
        if (target < 0) target = 0;
        if (target > longint'(32'hFFFF_FFFF)) target = longint'(32'hFFFF_FFFF);
        peak_lane = (start + 5 + $urandom_range(0, 4)) % LANES;
        p = set_lane(p, peak_lane, POWER_W'(target));
        if ($urandom_range(0, 3) == 0) p = set_lane(p, $urandom_range(0, LANES - 1),
                                                    POWER_W'(target));
      end
      7: begin
        base = $urandom();
        for (int i = 0; i < LANES; i++) p[i*POWER_W +: POWER_W] = base;
      end
      8: begin
        for (int i = 0; i < LANES; i++)
          if ($urandom_range(0, 3) == 0) p[i*POWER_W +: POWER_W] = $urandom();
      end
      default: begin
        for (int i = 0; i < LANES; i++)
          p[i*POWER_W +: POWER_W] = {16'hFFFF, 16'($urandom())};
      end
    endcase
    return p;
  endfunction

  task automatic add_probe(input logic [SET_W-1:0] powers, input logic lockout,
                           input logic clear, input logic typed, input logic hit,
                           input int ch, input int count, input logic pending);
    probe_row_t row;
    row.powers  = powers;
    row.lockout = lockout;
    row.clear   = clear;
    row.typed   = typed;
    row.want    = '{hit, CH_IDX_W'(ch), CNT_W'(count), pending};
    probes.push_back(row);
  endtask

  // One slave-side transfer, preceded by a random gap
  task automatic send_set(input logic [SET_W-1:0] powers, input logic lockout,
                          input logic clear, input logic typed, input mtd_result_t want);
    mtd_result_t predicted;
    int          gap;
    gap = idle_len(60);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= powers;
    s_axis_tuser  <= {clear, lockout};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = score_power_set(powers, lockout, clear);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Register write once the pipeline has drained
  task automatic load_factor(input logic [FACTOR_W-1:0] f);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    shadow_factor = f;
  endtask

  // Master side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin : result_check
    mtd_result_t got;
    mtd_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[CH_IDX_W-1:0], m_axis_tdata[CH_IDX_W +: CNT_W],
              m_axis_tuser[1]};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result hit=%0d ch=%0d count=%0d pending=%0d", $realtime,
                   got.hit, got.hit_channel, got.channel_count, got.hit_pending);
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit || got.hit_channel !== want.hit_channel ||
            got.channel_count !== want.channel_count || got.hit_pending !== want.hit_pending)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, want.hit, want.hit_channel, want.channel_count,
                     want.hit_pending, got.hit, got.hit_channel, got.channel_count,
                     got.hit_pending);
        end
      end
    end
    if (stall_left == 0) stall_left = idle_len(75);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [SET_W-1:0]    zeros;
    logic [SET_W-1:0]    ones;
    logic [SET_W-1:0]    ramp;
    logic [FACTOR_W-1:0] phase_factors [6];
    mtd_result_t         unused;
    zeros         = '0;
    ones          = {LANES{32'd1}};
    unused        = '0;
    shadow_factor = FACTOR_RESET;
    shadow_pending = 1'b0;
    for (int i = 0; i < LANES; i++) shadow_counts[i] = '0;
    for (int i = 0; i < LANES; i++) ramp[i*POWER_W +: POWER_W] = (LANES - i) << 16;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset factor
    add_probe(zeros, 0, 0, 1, 0, 0, 0, 0);                          // all zero after reset
    add_probe({LANES{32'hFFFF_FFFF}}, 0, 0, 1, 0, 0, 0, 0);         // all full scale
    add_probe(set_lane(zeros, 7, 1), 0, 0, 1, 1, 7, 1, 1);          // zero median, tiny peak
    add_probe(set_lane(zeros, 7, 1), 1, 0, 1, 0, 7, 1, 1);          // same under lockout
    add_probe({LANES{32'd5}}, 0, 1, 1, 0, 0, 0, 0);                 // clear, flat set
    add_probe(set_lane(zeros, 2, 32'hFFFF_FFFF), 0, 1, 1, 1, 2, 1, 1); // clear and hit together
    add_probe(set_lane(set_lane(zeros, 3, 32'hFFFF_FFFF), 8, 32'hFFFF_FFFF), 0, 0, 1,
              1, 3, 1, 1);                                          // tied peaks, lower wins
    add_probe(set_lane(ones, 9, 250), 0, 0, 1, 0, 9, 0, 1);         // peak equal to threshold
    add_probe(set_lane(ones, 9, 251), 0, 0, 1, 1, 9, 1, 1);         // one above threshold
    add_probe(set_lane(zeros, 0, 1), 1, 1, 1, 0, 0, 0, 0);          // lockout with clear
    add_probe(set_lane({LANES{32'hAAAA_AAAA}}, 6, 32'h5555_5555), 0, 0, 0, 0, 0, 0, 0);
    add_probe(ramp, 0, 0, 0, 0, 0, 0, 0);
    add_probe(set_lane(zeros, 9, 32'h0001_0000), 0, 1, 0, 0, 0, 0, 0);
    add_probe({LANES{32'h5555_5555}}, 1, 0, 0, 0, 0, 0, 0);
    add_probe(set_lane(ones, 1, 32'h8000_0000), 0, 0, 0, 0, 0, 0, 0);
    foreach (probes[k]) send_set(probes[k].powers, probes[k].lockout, probes[k].clear,
                                 probes[k].typed, probes[k].want);

    // Random phases across factor settings, one of them without idling
    phase_factors = '{10'd1, 10'd1023, 10'd0, 10'd0, 10'd3, FACTOR_RESET};
    phase_factors[3] = $urandom_range(2, 1022);
    for (int ph = 0; ph < 6; ph++) begin
      load_factor(phase_factors[ph]);
      no_idle = (ph == 4);
      for (int n = 0; n < PHASE_LEN; n++)
        send_set(random_power_set(), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                 1'b0, unused);
    end

    // Back-to-back hits on one lane
    load_factor(10'd1);
    no_idle = 1'b1;
    for (int n = 0; n < BURST_LEN; n++)
      send_set(set_lane(zeros, BURST_LANE, 1), 1'b0, 1'b0, 1'b0, unused);
    no_idle = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #(8_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ median_threshold_hit_detector_unit.f @@
rtl/core/mtd_pkg.sv
rtl/core/mtd_rank_lane.sv
rtl/core/mtd_merge.sv
rtl/core/mtd_hit_update.sv
rtl/core/median_threshold_hit_detector_unit.sv
dv/tb_top.sv
